>>> src/whpp_pkg.sv
// Shared types, sizes and state encoding of the weighted history pose predictor.
package whpp_pkg;

  localparam int HIST_DEPTH = 16;
  localparam int AXES       = 6;
  localparam int VAL_W      = 32;
  localparam int PTR_W      = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
  localparam int CNT_W      = $clog2(HIST_DEPTH + 1);
  localparam int AXIS_W     = $clog2(AXES);
  localparam int FACT_MAX   = HIST_DEPTH * (HIST_DEPTH + 1) / 2;
  localparam int FACT_W     = $clog2(FACT_MAX + 1);
  localparam int SUM_W      = VAL_W + FACT_W + 1;
  localparam int PROD_W     = VAL_W + CNT_W + 1;
  localparam int ROW_W      = AXES * VAL_W;

  localparam logic OP_STORE   = 1'b0;
  localparam logic OP_PREDICT = 1'b1;

  typedef struct packed {
    logic               operation;
    logic signed [31:0] x_in;
    logic signed [31:0] y_in;
    logic signed [31:0] z_in;
    logic signed [31:0] roll_in;
    logic signed [31:0] pitch_in;
    logic signed [31:0] yaw_in;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] x_out;
    logic signed [31:0] y_out;
    logic signed [31:0] z_out;
    logic signed [31:0] roll_out;
    logic signed [31:0] pitch_out;
    logic signed [31:0] yaw_out;
    logic               history_empty;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_DIV,
    ST_OUT
  } state_e;

endpackage

>>> src/whpp_ram.sv
// Generic simple dual-port RAM with registered read.
module whpp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                            clk_i,
  input  logic                            we_i,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                wdata_i,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr_i,
  output logic [WIDTH-1:0]                rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> src/whpp_div.sv
// Bit-serial restoring divider: signed weighted sum by positive weight total.
module whpp_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic signed [whpp_pkg::SUM_W-1:0] dividend_i,
  input  logic [whpp_pkg::FACT_W-1:0]     divisor_i,
  output logic                            done_o,
  output logic signed [whpp_pkg::VAL_W-1:0] quotient_o
);

  localparam int SW     = whpp_pkg::SUM_W;
  localparam int FW     = whpp_pkg::FACT_W;
  localparam int VW     = whpp_pkg::VAL_W;
  localparam int STEP_W = $clog2(SW);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              neg_q, neg_d;
  logic [SW-1:0]     quo_q, quo_d;
  logic [FW-1:0]     rem_q, rem_d;
  logic [FW-1:0]     div_q, div_d;
  logic [FW:0]       rem_sh;
  logic              ge;
  logic [VW-1:0]     mag;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    neg_d  = neg_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    div_d  = div_q;
    rem_sh = {rem_q, quo_q[SW-1]};
    ge     = (rem_sh >= {1'b0, div_q});
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      neg_d  = dividend_i[SW-1];
      quo_d  = dividend_i[SW-1] ? SW'(-dividend_i) : SW'(dividend_i);
      rem_d  = '0;
      div_d  = divisor_i;
    end else if (busy_q) begin
      // shift one dividend bit into the partial remainder, subtract if it fits
      rem_d  = ge ? FW'(rem_sh - {1'b0, div_q}) : FW'(rem_sh);
      quo_d  = {quo_q[SW-2:0], ge};
      step_d = step_q + 1'b1;
      if (step_q == STEP_W'(SW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  // truncation toward zero: negate the magnitude quotient
  assign mag        = quo_q[VW-1:0];
  assign quotient_o = neg_q ? VW'(-mag) : mag;
  assign done_o     = done_q;

endmodule

>>> src/weighted_history_pose_predictor.sv
// Top level of the weighted history pose predictor.
// Usage:
//   Input channel in_valid_i / in_stall_o / in_data_i carries one transaction per
//   item. operation = store writes x..yaw into a 16-entry ring (oldest entry is
//   overwritten once full) and gives no result. operation = predict gives one
//   result transaction on out_valid_o / out_stall_i / out_data_o: per axis the
//   linearly weighted average of the stored entries (weight 1 for the oldest up
//   to n for the newest, divided by n*(n+1)/2, truncated toward zero). With no
//   entries stored the result is all zeros with history_empty set, in the cycle
//   after acceptance.
// A prediction with n entries: each axis walks the ring through one
//   multiply-accumulate unit fed by the history RAM (one entry per cycle, plus
//   the registered-read bubble and a handoff), then a bit-serial divider takes
//   one bit of the 41-bit weighted sum per cycle and returns the quotient.
// in_stall_o is high from acceptance of a prediction until its result is
//   taken; one item is in work at a time.
// The result holds stable while out_stall_i is high.
// Reset clears the ring pointer and entry count; RAM contents stay undefined
//   and are never read before being written.
module weighted_history_pose_predictor (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  whpp_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output whpp_pkg::out_item_t out_data_o
);

  localparam int PW = whpp_pkg::PTR_W;
  localparam int CW = whpp_pkg::CNT_W;
  localparam int AW = whpp_pkg::AXIS_W;
  localparam int VW = whpp_pkg::VAL_W;
  localparam int SW = whpp_pkg::SUM_W;
  localparam int FW = whpp_pkg::FACT_W;

  whpp_pkg::state_e state_q, state_d;

  logic          in_acc;
  logic          store_go;
  logic          pred_go;

  // ring bookkeeping
  logic [PW-1:0] wp_q, wp_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [PW-1:0] oldest;

  // accumulation walk
  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] iss_q, iss_d;
  logic          pend_q, pend_d;
  logic [CW-1:0] wt_q, wt_d;
  logic [AW-1:0] axis_q, axis_d;
  logic signed [SW-1:0] acc_q, acc_d;
  logic [FW-1:0] fact_q, fact_d;
  logic          empty_q, empty_d;
  logic [2*CW-1:0] nn;

  logic signed [VW-1:0]                 res_q [whpp_pkg::AXES];
  logic signed [VW-1:0]                 val;
  logic signed [whpp_pkg::PROD_W-1:0]   prod;

  logic [whpp_pkg::ROW_W-1:0] ram_wdata, ram_rdata;

  logic                 mac_last;
  logic                 div_start;
  logic                 div_done;
  logic signed [VW-1:0] div_quo;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign store_go = in_acc && (in_data_i.operation == whpp_pkg::OP_STORE);
  assign pred_go  = in_acc && (in_data_i.operation == whpp_pkg::OP_PREDICT);

  // Pack one measurement per RAM row, x in the low word.
  assign ram_wdata = {in_data_i.yaw_in, in_data_i.pitch_in, in_data_i.roll_in,
                      in_data_i.z_in, in_data_i.y_in, in_data_i.x_in};

  whpp_ram #(
    .WIDTH(whpp_pkg::ROW_W),
    .DEPTH(whpp_pkg::HIST_DEPTH)
  ) u_hist (
    .clk_i  (clk_i),
    .we_i   (store_go),
    .waddr_i(wp_q),
    .wdata_i(ram_wdata),
    .raddr_i(rd_ptr_q),
    .rdata_o(ram_rdata)
  );

  // Oldest valid slot: write pointer minus entry count, modulo ring depth.
  always_comb begin
    if (CW'(wp_q) >= cnt_q) begin
      oldest = PW'(CW'(wp_q) - cnt_q);
    end else begin
      oldest = PW'(CW'(wp_q) + CW'(whpp_pkg::HIST_DEPTH) - cnt_q);
    end
  end

  // Axis word of the row returned by the RAM, weighted by its position.
  assign val  = ram_rdata[axis_q*VW +: VW];
  assign prod = val * $signed({1'b0, wt_q});
  assign nn   = cnt_q * (cnt_q + 1'b1);

  // Walk done once every entry is issued and the last read is accumulated.
  assign mac_last  = (iss_q == cnt_q) && !pend_q;
  assign div_start = (state_q == whpp_pkg::ST_MAC) && mac_last;

  whpp_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(acc_q),
    .divisor_i (fact_q),
    .done_o    (div_done),
    .quotient_o(div_quo)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      whpp_pkg::ST_IDLE: begin
        if (pred_go) begin
          state_d = (cnt_q == '0) ? whpp_pkg::ST_OUT : whpp_pkg::ST_MAC;
        end
      end
      whpp_pkg::ST_MAC: begin
        if (mac_last) begin
          state_d = whpp_pkg::ST_DIV;
        end
      end
      whpp_pkg::ST_DIV: begin
        if (div_done) begin
          state_d = (axis_q == AW'(whpp_pkg::AXES - 1)) ? whpp_pkg::ST_OUT
                                                        : whpp_pkg::ST_MAC;
        end
      end
      whpp_pkg::ST_OUT: begin
        if (!out_stall_i) begin
          state_d = whpp_pkg::ST_IDLE;
        end
      end
      default: state_d = whpp_pkg::ST_IDLE;
    endcase
  end

  // Datapath and bookkeeping updates.
  always_comb begin
    wp_d     = wp_q;
    cnt_d    = cnt_q;
    rd_ptr_d = rd_ptr_q;
    iss_d    = iss_q;
    pend_d   = 1'b0;
    wt_d     = wt_q;
    axis_d   = axis_q;
    acc_d    = acc_q;
    fact_d   = fact_q;
    empty_d  = empty_q;
    unique case (state_q)
      whpp_pkg::ST_IDLE: begin
        if (store_go) begin
          // advance the ring, saturate the count at the depth
          wp_d = (wp_q == PW'(whpp_pkg::HIST_DEPTH - 1)) ? '0 : wp_q + 1'b1;
          if (cnt_q != CW'(whpp_pkg::HIST_DEPTH)) begin
            cnt_d = cnt_q + 1'b1;
          end
        end
        if (pred_go) begin
          empty_d  = (cnt_q == '0);
          rd_ptr_d = oldest;
          iss_d    = '0;
          axis_d   = '0;
          acc_d    = '0;
          fact_d   = FW'(nn >> 1);
        end
      end
      whpp_pkg::ST_MAC: begin
        if (iss_q != cnt_q) begin
          // issue the next read; its weight is registered so it arrives with the RAM data
          rd_ptr_d = (rd_ptr_q == PW'(whpp_pkg::HIST_DEPTH - 1)) ? '0
                                                                : rd_ptr_q + 1'b1;
          iss_d    = iss_q + 1'b1;
          wt_d     = iss_q + 1'b1;
          pend_d   = 1'b1;
        end
        if (pend_q) begin
          acc_d = acc_q + SW'(prod);
        end
      end
      whpp_pkg::ST_DIV: begin
        if (div_done) begin
          // rewind the walk for the next axis
          axis_d   = axis_q + 1'b1;
          rd_ptr_d = oldest;
          iss_d    = '0;
          acc_d    = '0;
        end
      end
      whpp_pkg::ST_OUT: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= whpp_pkg::ST_IDLE;
      wp_q    <= '0;
      cnt_q   <= '0;
      iss_q   <= '0;
      pend_q  <= 1'b0;
      axis_q  <= '0;
    end else begin
      state_q <= state_d;
      wp_q    <= wp_d;
      cnt_q   <= cnt_d;
      iss_q   <= iss_d;
      pend_q  <= pend_d;
      axis_q  <= axis_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_ptr_q <= rd_ptr_d;
    wt_q     <= wt_d;
    acc_q    <= acc_d;
    fact_q   <= fact_d;
    empty_q  <= empty_d;
  end

  // Result words: clear on an empty-history request, fill one axis per division.
  always_ff @(posedge clk_i) begin
    if (pred_go && (cnt_q == '0)) begin
      for (int a = 0; a < whpp_pkg::AXES; a++) begin
        res_q[a] <= '0;
      end
    end else if ((state_q == whpp_pkg::ST_DIV) && div_done) begin
      res_q[axis_q] <= div_quo;
    end
  end

  assign in_stall_o  = (state_q != whpp_pkg::ST_IDLE);
  assign out_valid_o = (state_q == whpp_pkg::ST_OUT);

  assign out_data_o.x_out         = res_q[0];
  assign out_data_o.y_out         = res_q[1];
  assign out_data_o.z_out         = res_q[2];
  assign out_data_o.roll_out      = res_q[3];
  assign out_data_o.pitch_out     = res_q[4];
  assign out_data_o.yaw_out       = res_q[5];
  assign out_data_o.history_empty = empty_q;

endmodule

>>> sim/weighted_history_pose_predictor_tb.sv
// Self-checking testbench for the weighted history pose predictor.
`timescale 1ns / 1ps

module weighted_history_pose_predictor_tb;

  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_e;

  // Value shapes used when filling a measurement.
  typedef enum int {
    VAL_RANDOM,
    VAL_MAX,
    VAL_MIN,
    VAL_SMALL,
    VAL_CORNER
  } val_mode_e;

  typedef struct {
    whpp_pkg::in_item_t item;
    bit                 drain;  // hold this transaction until every prediction has come back
  } pending_t;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  whpp_pkg::in_item_t  in_data   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  whpp_pkg::out_item_t out_data;

  pending_t  pending_q[$];

  // Expected predictions, indexed by issue order. Both counters move by
  // nonblocking assignment, so the driver and monitor never race on them.
  whpp_pkg::out_item_t predicted_pose[int];
  int        pred_wr     = 0;
  int        pred_rd     = 0;
  int        items_done  = 0;
  int        items_queued = 0;
  int        errors      = 0;

  // Shadow of the measurement ring.
  logic signed [31:0] ring [whpp_pkg::AXES][whpp_pkg::HIST_DEPTH];
  int                 ring_wr    = 0;
  int                 ring_count = 0;

  weighted_history_pose_predictor DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  always #1 clk = ~clk;

  // Count a failure; print only the first ten.
  task automatic flag_error(input string msg);
    if (errors < 10) begin
      $display("[%0t] MISMATCH %s", $realtime, msg);
    end
    errors++;
  endtask

  task automatic check_field(input int idx, input string name,
                             input logic [31:0] exp_v, input logic [31:0] got_v);
    if (exp_v !== got_v) begin
      flag_error($sformatf("prediction %0d %s: expected %h, got %h", idx, name, exp_v, got_v));
    end
  endtask

  // Pick the idle probability from the current phase, which rotates every
  // 50 accepted transactions.
  function automatic bit take_gap(input bit is_sender);
    idle_mode_e m;
    int         pct;
    m = idle_mode_e'((items_done / 50) % 4);
    unique case (m)
      IDLE_NONE:     pct = 0;
      IDLE_SENDER:   pct = is_sender ? 71 : 0;
      IDLE_RECEIVER: pct = is_sender ? 0 : 71;
      default:       pct = 27;
    endcase
    return $urandom_range(0, 99) < pct;
  endfunction

  // Advance the shadow ring by one transaction; return the expected
  // prediction when the transaction asks for one.
  function automatic void fold_into_history(input whpp_pkg::in_item_t it,
                                            output bit has_res,
                                            output whpp_pkg::out_item_t res);
    logic signed [31:0] axis_v [whpp_pkg::AXES];
    longint             sum;
    longint             factor;
    int                 oldest;
    res     = '0;
    has_res = 1'b0;
    if (it.operation == whpp_pkg::OP_STORE) begin
      ring[0][ring_wr] = it.x_in;
      ring[1][ring_wr] = it.y_in;
      ring[2][ring_wr] = it.z_in;
      ring[3][ring_wr] = it.roll_in;
      ring[4][ring_wr] = it.pitch_in;
      ring[5][ring_wr] = it.yaw_in;
      ring_wr = (ring_wr + 1) % whpp_pkg::HIST_DEPTH;
      if (ring_count < whpp_pkg::HIST_DEPTH) ring_count++;
      return;
    end
    has_res = 1'b1;
    // Empty history: zeros with the empty flag raised.
    if (ring_count == 0) begin
      res.history_empty = 1'b1;
      return;
    end
    oldest = (ring_wr + whpp_pkg::HIST_DEPTH - ring_count) % whpp_pkg::HIST_DEPTH;
    factor = longint'(ring_count) * longint'(ring_count + 1) / 2;
    for (int a = 0; a < whpp_pkg::AXES; a++) begin
      sum = 0;
      for (int i = 0; i < ring_count; i++) begin
        sum += longint'(i + 1) *
               longint'(ring[a][(oldest + i) % whpp_pkg::HIST_DEPTH]);
      end
      // Signed longint division truncates toward zero.
      axis_v[a] = 32'(sum / factor);
    end
    res.x_out     = axis_v[0];
    res.y_out     = axis_v[1];
    res.z_out     = axis_v[2];
    res.roll_out  = axis_v[3];
    res.pitch_out = axis_v[4];
    res.yaw_out   = axis_v[5];
  endfunction

  function automatic logic [31:0] pick_value(input val_mode_e mode);
    unique case (mode)
      VAL_MAX:   return 32'h7FFF_FFFF;
      VAL_MIN:   return 32'h8000_0000;
      VAL_SMALL: return 32'($signed($urandom_range(0, 131071)) - 65536);
      VAL_CORNER: begin
        unique case ($urandom_range(0, 4))
          0:       return 32'h7FFF_FFFF;
          1:       return 32'h8000_0000;
          2:       return 32'h0000_0000;
          3:       return 32'hFFFF_FFFF;
          default: return 32'h0000_0001;
        endcase
      end
      default:   return $urandom;
    endcase
  endfunction

  function automatic whpp_pkg::in_item_t make_item(input logic op, input val_mode_e mode);
    whpp_pkg::in_item_t it;
    it.operation = op;
    it.x_in      = pick_value(mode);
    it.y_in      = pick_value(mode);
    it.z_in      = pick_value(mode);
    it.roll_in   = pick_value(mode);
    it.pitch_in  = pick_value(mode);
    it.yaw_in    = pick_value(mode);
    return it;
  endfunction

  function automatic whpp_pkg::in_item_t make_uniform(input logic op, input logic [31:0] v);
    whpp_pkg::in_item_t it;
    it = {op, v, v, v, v, v, v};
    return it;
  endfunction

  task automatic push_item(input whpp_pkg::in_item_t it, input bit drain);
    pending_t p;
    p.item  = it;
    p.drain = drain;
    pending_q.insert(pending_q.size(), p);
    items_queued++;
  endtask

  // Driver: fold each accepted transaction into the shadow ring, then
  // present the next pending one unless this cycle is a gap.
  always @(posedge clk or negedge rst_n) begin
    bit                  has_res;
    whpp_pkg::out_item_t res;
    int                  outstanding;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      outstanding = pred_wr - pred_rd;
      if (in_valid && !in_stall) begin
        fold_into_history(in_data, has_res, res);
        if (has_res) begin
          predicted_pose[pred_wr] = res;
          pred_wr <= pred_wr + 1;
          outstanding++;
        end
        items_done <= items_done + 1;
      end
      // Hold a stalled payload; otherwise the slot is free for a new one.
      if (!in_valid || !in_stall) begin
        if (pending_q.size() > 0 && !take_gap(1'b1) &&
            !(pending_q[0].drain && outstanding != 0)) begin
          in_data  <= pending_q[0].item;
          in_valid <= 1'b1;
          void'(pending_q.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare every accepted result with the oldest prediction.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pred_rd == pred_wr) begin
          flag_error("result transaction with no prediction pending");
        end else begin
          check_field(pred_rd, "x_out", predicted_pose[pred_rd].x_out, out_data.x_out);
          check_field(pred_rd, "y_out", predicted_pose[pred_rd].y_out, out_data.y_out);
          check_field(pred_rd, "z_out", predicted_pose[pred_rd].z_out, out_data.z_out);
          check_field(pred_rd, "roll_out", predicted_pose[pred_rd].roll_out,
                      out_data.roll_out);
          check_field(pred_rd, "pitch_out", predicted_pose[pred_rd].pitch_out,
                      out_data.pitch_out);
          check_field(pred_rd, "yaw_out", predicted_pose[pred_rd].yaw_out,
                      out_data.yaw_out);
          check_field(pred_rd, "history_empty", 32'(predicted_pose[pred_rd].history_empty),
                      32'(out_data.history_empty));
          predicted_pose.delete(pred_rd);
          pred_rd <= pred_rd + 1;
        end
      end
      out_stall <= take_gap(1'b0);
    end
  end

  // Stimulus and end of run.
  initial begin
    whpp_pkg::in_item_t it;
    int                 kind;
    int                 run;
    val_mode_e          mode;

    // Directed part. Predict on an empty history, with store fields set
    // that must be ignored.
    push_item(make_uniform(whpp_pkg::OP_PREDICT, 32'hFFFF_FFFF), 1'b0);
    push_item(make_uniform(whpp_pkg::OP_STORE, 32'h7FFF_FFFF), 1'b0);
    push_item(make_uniform(whpp_pkg::OP_PREDICT, 32'h0000_0000), 1'b0);
    push_item(make_uniform(whpp_pkg::OP_STORE, 32'h8000_0000), 1'b0);
    push_item(make_uniform(whpp_pkg::OP_PREDICT, 32'h5555_5555), 1'b0);
    it = {whpp_pkg::OP_STORE, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000,
          32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0001};
    push_item(it, 1'b0);
    // Back-to-back predictions.
    push_item(make_uniform(whpp_pkg::OP_PREDICT, 32'hAAAA_AAAA), 1'b0);
    push_item(make_uniform(whpp_pkg::OP_PREDICT, 32'h0000_0000), 1'b0);
    // Overfill the ring with the most negative value: the wrap drops the
    // older entries and the average lands exactly on the minimum.
    push_item(make_uniform(whpp_pkg::OP_STORE, 32'h8000_0000), 1'b1);
    repeat (15) push_item(make_uniform(whpp_pkg::OP_STORE, 32'h8000_0000), 1'b0);
    push_item(make_uniform(whpp_pkg::OP_PREDICT, 32'h0000_0000), 1'b0);

    // Random part: mostly runs of stores closed by a prediction, with lone
    // and back-to-back predictions mixed in. Drain the block now and then.
    while (items_queued < 750) begin
      kind = $urandom_range(0, 9);
      mode = val_mode_e'($urandom_range(0, 4));
      if (kind < 6) begin
        run = $urandom_range(1, 20);
        repeat (run) push_item(make_item(whpp_pkg::OP_STORE, mode),
                               items_queued % 120 == 0);
        push_item(make_item(whpp_pkg::OP_PREDICT, VAL_RANDOM), 1'b0);
      end else if (kind < 8) begin
        push_item(make_item(whpp_pkg::OP_PREDICT, VAL_RANDOM), items_queued % 120 == 0);
      end else begin
        repeat ($urandom_range(2, 4)) push_item(make_item(whpp_pkg::OP_PREDICT, VAL_RANDOM),
                                                1'b0);
      end
    end

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Wait for the queue to empty and every prediction to come back, then
    // give the block at least one worst-case prediction latency to misbehave.
    while (pending_q.size() != 0 || in_valid || pred_wr != pred_rd) @(posedge clk);
    repeat (400) @(posedge clk);

    if (errors == 0 && pred_wr == pred_rd) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Timeout: far beyond the slowest correct run.
  initial begin
    #4_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

>>> weighted_history_pose_predictor.f
src/whpp_pkg.sv
src/whpp_ram.sv
src/whpp_div.sv
src/weighted_history_pose_predictor.sv
sim/weighted_history_pose_predictor_tb.sv
